FILE: design/mglt_pkg.sv
// ----------------------------------------------------------------------------
// mglt_pkg
// Types, codes and mode helpers shared by the multi-granularity lock table.
// ----------------------------------------------------------------------------
package mglt_pkg;

   localparam int unsigned KeyWidth = 41;
   localparam int unsigned TxnWidth = 16;

   // lock modes
   localparam logic [2:0] MODE_IS  = 3'd0;
   localparam logic [2:0] MODE_IX  = 3'd1;
   localparam logic [2:0] MODE_S   = 3'd2;
   localparam logic [2:0] MODE_X   = 3'd3;
   localparam logic [2:0] MODE_SIX = 3'd4;

   // transaction phases
   localparam logic [1:0] PH_DEFAULT   = 2'd0;
   localparam logic [1:0] PH_GROWING   = 2'd1;
   localparam logic [1:0] PH_SHRINKING = 2'd2;
   localparam logic [1:0] PH_ABORTED   = 2'd3;

   // result status
   localparam logic [2:0] ST_GRANTED        = 3'd0;
   localparam logic [2:0] ST_RELEASED       = 3'd1;
   localparam logic [2:0] ST_NOT_FOUND      = 3'd2;
   localparam logic [2:0] ST_ABORT_SHRINK   = 3'd3;
   localparam logic [2:0] ST_ABORT_UPGRADE  = 3'd4;
   localparam logic [2:0] ST_ABORT_CONFLICT = 3'd5;
   localparam logic [2:0] ST_NO_TXN         = 3'd6;
   localparam logic [2:0] ST_FULL           = 3'd7;

   // request kinds
   localparam logic KIND_LOCK   = 1'b0;
   localparam logic KIND_UNLOCK = 1'b1;

   // group mode codes
   localparam logic [2:0] GRP_NONE = 3'd0;
   localparam logic [2:0] GRP_IS   = 3'd1;
   localparam logic [2:0] GRP_IX   = 3'd2;
   localparam logic [2:0] GRP_S    = 3'd3;
   localparam logic [2:0] GRP_SIX  = 3'd4;
   localparam logic [2:0] GRP_X    = 3'd5;

   typedef struct packed {
      logic        kind;
      logic        txn_present;
      logic [15:0] txn_id;
      logic [1:0]  txn_phase;
      logic [2:0]  access_mode;
      logic        target_is_record;
      logic [7:0]  table_id;
      logic [19:0] page_number;
      logic [11:0] slot_number;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [1:0] new_phase;
      logic [2:0] group_mode;
   } rsp_type;

   // classified request as queued between front and back
   typedef struct packed {
      logic                kind;
      logic                present;
      logic [TxnWidth-1:0] txn;
      logic [1:0]          phase;
      logic [2:0]          mode;
      logic [KeyWidth-1:0] key;
   } work_type;

   typedef struct packed {
      logic                valid;
      logic [KeyWidth-1:0] key;
      logic [2:0]          grp;
   } entry_type;

   typedef struct packed {
      logic                valid;
      logic [TxnWidth-1:0] txn;
      logic [2:0]          mode;
   } holder_type;

   // is mode a compatible with mode b held by another transaction
   function automatic logic compat(input logic [2:0] a, input logic [2:0] b);
      logic r;
      unique case (a)
         MODE_S:   r = (b == MODE_S) || (b == MODE_IS);
         MODE_IS:  r = (b != MODE_X);
         MODE_IX:  r = (b == MODE_IS) || (b == MODE_IX);
         MODE_SIX: r = (b == MODE_IS);
         default:  r = 1'b0;
      endcase
      return r;
   endfunction

   function automatic logic covers(input logic [2:0] held, input logic [2:0] req);
      logic r;
      if (held == req || held == MODE_X) begin
         r = 1'b1;
      end else if (held == MODE_SIX) begin
         r = (req == MODE_S) || (req == MODE_IS) || (req == MODE_IX);
      end else if (held == MODE_S || held == MODE_IX) begin
         r = (req == MODE_IS);
      end else begin
         r = 1'b0;
      end
      return r;
   endfunction

   function automatic logic [2:0] group_code(input logic [2:0] m);
      logic [2:0] r;
      unique case (m)
         MODE_IS:  r = GRP_IS;
         MODE_IX:  r = GRP_IX;
         MODE_S:   r = GRP_S;
         MODE_SIX: r = GRP_SIX;
         default:  r = GRP_X;
      endcase
      return r;
   endfunction

endpackage

FILE: design/mglt_front.sv
// ----------------------------------------------------------------------------
// mglt_front
// Accepts requests, builds the resource key, folds undefined modes into X and
// queues the classified item for the back end in a two-entry queue.
// ----------------------------------------------------------------------------
module mglt_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  mglt_pkg::req_type   req_data,
   output logic                q_valid,
   output mglt_pkg::work_type  q_item,
   input  logic                q_pop
);

   mglt_pkg::work_type q_mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   mglt_pkg::work_type cls;

   always_comb begin
      cls.kind    = req_data.kind;
      cls.present = req_data.txn_present;
      cls.txn     = req_data.txn_id;
      cls.phase   = req_data.txn_phase;
      cls.mode    = (req_data.access_mode > mglt_pkg::MODE_SIX) ? mglt_pkg::MODE_X
                                                                 : req_data.access_mode;
      cls.key     = {req_data.target_is_record, req_data.table_id,
                     req_data.page_number, req_data.slot_number};
   end

   assign req_ready = (count_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign q_valid   = (count_ff != 2'd0);
   assign q_item    = q_mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ (q_pop && q_valid);
      count_in  = count_ff + 2'(push) - 2'(q_pop && q_valid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

FILE: design/mglt_back.sv
// ----------------------------------------------------------------------------
// mglt_back
// Carries out one request at a time: key scan over the entry memory, holder
// row read and two holder passes for a found key, then the update and result.
// ----------------------------------------------------------------------------
module mglt_back #(
   parameter int unsigned LOCK_ENTRIES      = 64,
   parameter int unsigned HOLDERS_PER_ENTRY = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  mglt_pkg::work_type  q_item,
   output logic                q_pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output mglt_pkg::rsp_type   rsp_data
);

   localparam int unsigned AW = (LOCK_ENTRIES > 1) ? $clog2(LOCK_ENTRIES) : 1;
   localparam int unsigned HW = (HOLDERS_PER_ENTRY > 1) ? $clog2(HOLDERS_PER_ENTRY) : 1;

   typedef mglt_pkg::holder_type [HOLDERS_PER_ENTRY-1:0] row_type;

   typedef enum logic [8:0] {
      S_CLEAR = 9'b000000001,
      S_IDLE  = 9'b000000010,
      S_SCAN  = 9'b000000100,
      S_HRD   = 9'b000001000,
      S_HLD   = 9'b000010000,
      S_P1    = 9'b000100000,
      S_MOD   = 9'b001000000,
      S_P2    = 9'b010000000,
      S_FIN   = 9'b100000000
   } state_type;

   mglt_pkg::entry_type entry_mem [LOCK_ENTRIES];
   row_type             hold_mem  [LOCK_ENTRIES];

   state_type           state_ff, state_in;
   mglt_pkg::work_type  item_ff, item_in;
   logic [AW:0]         scan_ff, scan_in;
   logic                cmp_v_ff, cmp_v_in;
   logic [AW-1:0]       cmp_idx_ff, cmp_idx_in;
   logic                found_ff, found_in;
   logic [AW-1:0]       ent_ff, ent_in;
   logic [2:0]          ent_grp_ff, ent_grp_in;
   logic                free_e_v_ff, free_e_v_in;
   logic [AW-1:0]       free_e_ff, free_e_in;
   logic [HW-1:0]       h_ff, h_in;
   logic                mine_v_ff, mine_v_in;
   logic [HW-1:0]       mine_ff, mine_in;
   logic                freeh_v_ff, freeh_v_in;
   logic [HW-1:0]       freeh_ff, freeh_in;
   logic                skip_v_ff, skip_v_in;
   logic [HW-1:0]       skip_ff, skip_in;
   logic                cov_ff, cov_in;
   logic                fits_ff, fits_in;
   logic [2:0]          grp_ff, grp_in;
   row_type             row_ff, row_in;
   logic [AW-1:0]       clr_ff, clr_in;
   logic                rsp_valid_ff, rsp_valid_in;
   mglt_pkg::rsp_type   rsp_data_ff, rsp_data_in;

   mglt_pkg::entry_type ent_rd_ff;
   row_type             hold_rd_ff;

   logic                ent_we, hold_we;
   logic [AW-1:0]       ent_wa, ent_ra, hold_wa, hold_ra;
   mglt_pkg::entry_type ent_wd;
   row_type             hold_wd;
   row_type             fresh_row;
   logic                out_free;
   logic [1:0]          ph;
   logic [2:0]          held, want;
   logic [2:0]          cand;
   mglt_pkg::holder_type hcur;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign hcur      = row_ff[h_ff];
   assign held      = row_ff[mine_ff].mode;
   // mode checked against the other holders; the request itself on a full row
   assign cand      = skip_v_ff ? row_ff[skip_ff].mode : item_ff.mode;

   always_comb begin
      for (int i = 0; i < HOLDERS_PER_ENTRY; i++) begin
         fresh_row[i] = '0;
      end
      fresh_row[0] = '{valid: 1'b1, txn: item_ff.txn, mode: item_ff.mode};
   end

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      scan_in      = scan_ff;
      cmp_v_in     = 1'b0;
      cmp_idx_in   = cmp_idx_ff;
      found_in     = found_ff;
      ent_in       = ent_ff;
      ent_grp_in   = ent_grp_ff;
      free_e_v_in  = free_e_v_ff;
      free_e_in    = free_e_ff;
      h_in         = h_ff;
      mine_v_in    = mine_v_ff;
      mine_in      = mine_ff;
      freeh_v_in   = freeh_v_ff;
      freeh_in     = freeh_ff;
      skip_v_in    = skip_v_ff;
      skip_in      = skip_ff;
      cov_in       = cov_ff;
      fits_in      = fits_ff;
      grp_in       = grp_ff;
      row_in       = row_ff;
      clr_in       = clr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      q_pop        = 1'b0;
      ent_we       = 1'b0;
      ent_wa       = ent_ff;
      ent_wd       = '0;
      ent_ra       = '0;
      hold_we      = 1'b0;
      hold_wa      = ent_ff;
      hold_wd      = row_ff;
      hold_ra      = ent_ff;
      ph           = item_ff.phase;
      want         = item_ff.mode;

      unique case (state_ff)
         S_CLEAR: begin
            ent_we = 1'b1;
            ent_wa = clr_ff;
            clr_in = clr_ff + AW'(1);
            if (clr_ff == AW'(LOCK_ENTRIES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            q_pop = q_valid;
            if (q_valid) begin
               item_in     = q_item;
               scan_in     = '0;
               found_in    = 1'b0;
               free_e_v_in = 1'b0;
               state_in    = q_item.present ? S_SCAN : S_FIN;
            end
         end
         S_SCAN: begin
            // reads go out one per cycle; each compare uses the registered read data
            if (scan_ff < (AW+1)'(LOCK_ENTRIES)) begin
               ent_ra     = scan_ff[AW-1:0];
               cmp_v_in   = 1'b1;
               cmp_idx_in = scan_ff[AW-1:0];
               scan_in    = scan_ff + (AW+1)'(1);
            end
            if (cmp_v_ff) begin
               if (ent_rd_ff.valid && ent_rd_ff.key == item_ff.key) begin
                  found_in   = 1'b1;
                  ent_in     = cmp_idx_ff;
                  ent_grp_in = ent_rd_ff.grp;
                  state_in   = S_HRD;
               end else begin
                  if (!ent_rd_ff.valid && !free_e_v_ff) begin
                     free_e_v_in = 1'b1;
                     free_e_in   = cmp_idx_ff;
                  end
                  if (cmp_idx_ff == AW'(LOCK_ENTRIES - 1)) begin
                     state_in = S_FIN;
                  end
               end
            end
         end
         S_HRD: begin
            state_in = S_HLD;
         end
         S_HLD: begin
            row_in     = hold_rd_ff;
            h_in       = '0;
            mine_v_in  = 1'b0;
            freeh_v_in = 1'b0;
            state_in   = S_P1;
         end
         S_P1: begin
            if (hcur.valid) begin
               if (!mine_v_ff && hcur.txn == item_ff.txn) begin
                  mine_v_in = 1'b1;
                  mine_in   = h_ff;
               end
            end else if (!freeh_v_ff) begin
               freeh_v_in = 1'b1;
               freeh_in   = h_ff;
            end
            h_in = h_ff + HW'(1);
            if (h_ff == HW'(HOLDERS_PER_ENTRY - 1)) begin
               state_in = S_MOD;
            end
         end
         S_MOD: begin
            cov_in    = 1'b0;
            skip_v_in = 1'b0;
            if (mine_v_ff) begin
               skip_v_in = 1'b1;
               skip_in   = mine_ff;
               if (item_ff.kind == mglt_pkg::KIND_UNLOCK) begin
                  row_in[mine_ff].valid = 1'b0;
               end else begin
                  cov_in = mglt_pkg::covers(held, item_ff.mode);
                  want   = mglt_pkg::covers(item_ff.mode, held) ? item_ff.mode
                                                                : mglt_pkg::MODE_SIX;
                  row_in[mine_ff].mode = want;
               end
            end else if (freeh_v_ff) begin
               skip_v_in = 1'b1;
               skip_in   = freeh_ff;
               row_in[freeh_ff] = '{valid: 1'b1, txn: item_ff.txn, mode: item_ff.mode};
            end
            fits_in  = 1'b1;
            grp_in   = mglt_pkg::GRP_NONE;
            h_in     = '0;
            state_in = S_P2;
         end
         S_P2: begin
            if (hcur.valid) begin
               if (mglt_pkg::group_code(hcur.mode) > grp_ff) begin
                  grp_in = mglt_pkg::group_code(hcur.mode);
               end
               if (!(skip_v_ff && skip_ff == h_ff)) begin
                  if (!mglt_pkg::compat(cand, hcur.mode) ||
                      !mglt_pkg::compat(hcur.mode, cand)) begin
                     fits_in = 1'b0;
                  end
               end
            end
            h_in = h_ff + HW'(1);
            if (h_ff == HW'(HOLDERS_PER_ENTRY - 1)) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (out_free) begin
               priority if (!item_ff.present) begin
                  rsp_data_in = '{mglt_pkg::ST_NO_TXN, ph, mglt_pkg::GRP_NONE};
               end else if (item_ff.kind == mglt_pkg::KIND_UNLOCK) begin
                  if (!found_ff || !mine_v_ff) begin
                     rsp_data_in = '{mglt_pkg::ST_NOT_FOUND, ph,
                                     found_ff ? ent_grp_ff : mglt_pkg::GRP_NONE};
                  end else begin
                     if (ph == mglt_pkg::PH_GROWING) begin
                        ph = mglt_pkg::PH_SHRINKING;
                     end
                     hold_we     = 1'b1;
                     ent_we      = 1'b1;
                     ent_wd      = '{valid: (grp_ff != mglt_pkg::GRP_NONE),
                                     key: item_ff.key, grp: grp_ff};
                     rsp_data_in = '{mglt_pkg::ST_RELEASED, ph, grp_ff};
                  end
               end else if (ph == mglt_pkg::PH_SHRINKING) begin
                  rsp_data_in = '{mglt_pkg::ST_ABORT_SHRINK, mglt_pkg::PH_ABORTED,
                                  found_ff ? ent_grp_ff : mglt_pkg::GRP_NONE};
               end else begin
                  if (ph == mglt_pkg::PH_DEFAULT) begin
                     ph = mglt_pkg::PH_GROWING;
                  end
                  if (found_ff) begin
                     if (mine_v_ff && cov_ff) begin
                        rsp_data_in = '{mglt_pkg::ST_GRANTED, ph, ent_grp_ff};
                     end else if (!fits_ff) begin
                        rsp_data_in = '{mine_v_ff ? mglt_pkg::ST_ABORT_UPGRADE
                                                  : mglt_pkg::ST_ABORT_CONFLICT,
                                        mglt_pkg::PH_ABORTED, ent_grp_ff};
                     end else if (!mine_v_ff && !freeh_v_ff) begin
                        rsp_data_in = '{mglt_pkg::ST_FULL, ph, ent_grp_ff};
                     end else begin
                        hold_we     = 1'b1;
                        ent_we      = 1'b1;
                        ent_wd      = '{valid: 1'b1, key: item_ff.key, grp: grp_ff};
                        rsp_data_in = '{mglt_pkg::ST_GRANTED, ph, grp_ff};
                     end
                  end else if (!free_e_v_ff) begin
                     rsp_data_in = '{mglt_pkg::ST_FULL, ph, mglt_pkg::GRP_NONE};
                  end else begin
                     hold_we     = 1'b1;
                     hold_wa     = free_e_ff;
                     hold_wd     = fresh_row;
                     ent_we      = 1'b1;
                     ent_wa      = free_e_ff;
                     ent_wd      = '{valid: 1'b1, key: item_ff.key,
                                     grp: mglt_pkg::group_code(item_ff.mode)};
                     rsp_data_in = '{mglt_pkg::ST_GRANTED, ph,
                                     mglt_pkg::group_code(item_ff.mode)};
                  end
               end
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      scan_ff     <= scan_in;
      cmp_v_ff    <= cmp_v_in;
      cmp_idx_ff  <= cmp_idx_in;
      found_ff    <= found_in;
      ent_ff      <= ent_in;
      ent_grp_ff  <= ent_grp_in;
      free_e_v_ff <= free_e_v_in;
      free_e_ff   <= free_e_in;
      h_ff        <= h_in;
      mine_v_ff   <= mine_v_in;
      mine_ff     <= mine_in;
      freeh_v_ff  <= freeh_v_in;
      freeh_ff    <= freeh_in;
      skip_v_ff   <= skip_v_in;
      skip_ff     <= skip_in;
      cov_ff      <= cov_in;
      fits_ff     <= fits_in;
      grp_ff      <= grp_in;
      row_ff      <= row_in;
      rsp_data_ff <= rsp_data_in;
   end

   // entry memory
   always_ff @(posedge clock) begin
      if (ent_we) begin
         entry_mem[ent_wa] <= ent_wd;
      end
      ent_rd_ff <= entry_mem[ent_ra];
   end

   // holder row memory
   always_ff @(posedge clock) begin
      if (hold_we) begin
         hold_mem[hold_wa] <= hold_wd;
      end
      hold_rd_ff <= hold_mem[hold_ra];
   end

endmodule

FILE: design/multi_granularity_lock_table.sv
// ----------------------------------------------------------------------------
// multi_granularity_lock_table
// No-wait lock table for IS, IX, S, SIX and X modes over table/record keys.
// ----------------------------------------------------------------------------
// Requests enter on req_valid/req_ready with one req_type payload; each
// request gives exactly one rsp_type result on rsp_valid/rsp_ready.
// A two-entry queue sits behind the request port, so up to two requests are
// taken while the back end is busy or the result waits to be taken.
// The back end handles one request at a time. The key scan reads the entry
// memory one entry per cycle, and the two holder passes visit one holder per
// cycle; a key that is not found skips the holder passes, and a request
// without a transaction skips the scan as well.
// After reset a clearing pass marks all entries free;
// requests are queued but not processed until it ends.
// A result stays on rsp_data until taken; while the receiver stalls the back
// end holds its next finished result and the queue fills, then req_ready
// drops.
// ----------------------------------------------------------------------------
module multi_granularity_lock_table #(
   parameter int unsigned LOCK_ENTRIES      = 64,
   parameter int unsigned HOLDERS_PER_ENTRY = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  mglt_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output mglt_pkg::rsp_type  rsp_data
);

   logic               q_valid;
   logic               q_pop;
   mglt_pkg::work_type q_item;

   mglt_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop)
   );

   mglt_back #(
      .LOCK_ENTRIES      (LOCK_ENTRIES),
      .HOLDERS_PER_ENTRY (HOLDERS_PER_ENTRY)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: design/mglt_checker.sv
// ----------------------------------------------------------------------------
// mglt_checker
// Port-level checks on the lock table's result channel.
// ----------------------------------------------------------------------------
module mglt_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input mglt_pkg::rsp_type rsp_data
);

   // stalled transfer keeps its result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_abort_phase: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == mglt_pkg::ST_ABORT_SHRINK ||
                    rsp_data.status == mglt_pkg::ST_ABORT_UPGRADE ||
                    rsp_data.status == mglt_pkg::ST_ABORT_CONFLICT)
      |-> rsp_data.new_phase == mglt_pkg::PH_ABORTED)
      else $error("abort without aborted phase");

   a_release_phase: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == mglt_pkg::ST_RELEASED
      |-> rsp_data.new_phase != mglt_pkg::PH_GROWING)
      else $error("release left the transaction growing");

   a_no_txn_group: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == mglt_pkg::ST_NO_TXN
      |-> rsp_data.group_mode == mglt_pkg::GRP_NONE)
      else $error("no-transaction result with a group mode");

endmodule

bind multi_granularity_lock_table mglt_checker u_checker (.*);

FILE: dv/mglt_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mglt_scoreboard
// Watches the request and result channels of the lock table, keeps its own
// copy of the entry and holder tables, and compares every result transfer
// with the oldest predicted result.
// ----------------------------------------------------------------------------
module mglt_scoreboard #(
   parameter int unsigned LOCK_ENTRIES      = 64,
   parameter int unsigned HOLDERS_PER_ENTRY = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  mglt_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  mglt_pkg::rsp_type rsp_data,
   output int                fail_count,
   output int                pending
);

   localparam int NH = LOCK_ENTRIES * HOLDERS_PER_ENTRY;

   logic              ent_used [LOCK_ENTRIES];
   logic [40:0]       ent_key  [LOCK_ENTRIES];
   logic [2:0]        ent_grp  [LOCK_ENTRIES];
   logic              hold_used[NH];
   logic [15:0]       hold_txn [NH];
   logic [2:0]        hold_mode[NH];
   mglt_pkg::rsp_type lock_results[$];

   function automatic logic mode_ok(input logic [2:0] a, input logic [2:0] b);
      case (a)
         mglt_pkg::MODE_S:   return (b == mglt_pkg::MODE_S) || (b == mglt_pkg::MODE_IS);
         mglt_pkg::MODE_IS:  return b != mglt_pkg::MODE_X;
         mglt_pkg::MODE_IX:  return (b == mglt_pkg::MODE_IS) || (b == mglt_pkg::MODE_IX);
         mglt_pkg::MODE_SIX: return b == mglt_pkg::MODE_IS;
         default:            return 1'b0;
      endcase
   endfunction

   function automatic logic mode_covers(input logic [2:0] h, input logic [2:0] r);
      if (h == r || h == mglt_pkg::MODE_X) return 1'b1;
      if (h == mglt_pkg::MODE_SIX)
         return r == mglt_pkg::MODE_S || r == mglt_pkg::MODE_IS || r == mglt_pkg::MODE_IX;
      if (h == mglt_pkg::MODE_S || h == mglt_pkg::MODE_IX) return r == mglt_pkg::MODE_IS;
      return 1'b0;
   endfunction

   function automatic logic [2:0] grp_of(input logic [2:0] m);
      case (m)
         mglt_pkg::MODE_IS:  return mglt_pkg::GRP_IS;
         mglt_pkg::MODE_IX:  return mglt_pkg::GRP_IX;
         mglt_pkg::MODE_S:   return mglt_pkg::GRP_S;
         mglt_pkg::MODE_SIX: return mglt_pkg::GRP_SIX;
         default:            return mglt_pkg::GRP_X;
      endcase
   endfunction

   function automatic void regroup(input int e);
      logic [2:0] g;
      int i;
      g = mglt_pkg::GRP_NONE;
      for (int h = 0; h < HOLDERS_PER_ENTRY; h++) begin
         i = e * HOLDERS_PER_ENTRY + h;
         if (hold_used[i] && grp_of(hold_mode[i]) > g) g = grp_of(hold_mode[i]);
      end
      ent_grp[e] = g;
   endfunction

   function automatic logic fits_all(input int e, input int skip, input logic [2:0] m);
      int i;
      for (int h = 0; h < HOLDERS_PER_ENTRY; h++) begin
         i = e * HOLDERS_PER_ENTRY + h;
         if (h != skip && hold_used[i])
            if (!mode_ok(m, hold_mode[i]) || !mode_ok(hold_mode[i], m)) return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic mglt_pkg::rsp_type lock_step(input mglt_pkg::req_type r);
      mglt_pkg::rsp_type o;
      logic [40:0] k;
      logic [2:0]  m, want;
      logic [1:0]  ph;
      int ent, mine, freeh, i;
      k = {r.target_is_record, r.table_id, r.page_number, r.slot_number};
      m = (r.access_mode > mglt_pkg::MODE_SIX) ? mglt_pkg::MODE_X : r.access_mode;
      ph = r.txn_phase;
      ent = -1; mine = -1; freeh = -1;
      o.group_mode = mglt_pkg::GRP_NONE;
      if (!r.txn_present) begin
         o.status = mglt_pkg::ST_NO_TXN; o.new_phase = ph; return o;
      end
      for (int e = 0; e < LOCK_ENTRIES; e++)
         if (ent < 0 && ent_used[e] && ent_key[e] == k) ent = e;
      if (ent >= 0) begin
         o.group_mode = ent_grp[ent];
         for (int h = 0; h < HOLDERS_PER_ENTRY; h++) begin
            i = ent * HOLDERS_PER_ENTRY + h;
            if (hold_used[i]) begin
               if (mine < 0 && hold_txn[i] == r.txn_id) mine = h;
            end else if (freeh < 0) begin
               freeh = h;
            end
         end
      end
      if (r.kind == mglt_pkg::KIND_UNLOCK) begin
         if (mine < 0) begin
            o.status = mglt_pkg::ST_NOT_FOUND; o.new_phase = ph; return o;
         end
         hold_used[ent*HOLDERS_PER_ENTRY+mine] = 1'b0;
         if (ph == mglt_pkg::PH_GROWING) ph = mglt_pkg::PH_SHRINKING;
         regroup(ent);
         o.group_mode = ent_grp[ent];
         if (ent_grp[ent] == mglt_pkg::GRP_NONE) ent_used[ent] = 1'b0;
         o.status = mglt_pkg::ST_RELEASED; o.new_phase = ph; return o;
      end
      if (ph == mglt_pkg::PH_SHRINKING) begin
         o.status = mglt_pkg::ST_ABORT_SHRINK; o.new_phase = mglt_pkg::PH_ABORTED;
         return o;
      end
      if (ph == mglt_pkg::PH_DEFAULT) ph = mglt_pkg::PH_GROWING;
      o.new_phase = ph;
      if (mine >= 0) begin
         i = ent * HOLDERS_PER_ENTRY + mine;
         if (mode_covers(hold_mode[i], m)) begin
            o.status = mglt_pkg::ST_GRANTED; return o;
         end
         want = mode_covers(m, hold_mode[i]) ? m : mglt_pkg::MODE_SIX;
         if (!fits_all(ent, mine, want)) begin
            o.status = mglt_pkg::ST_ABORT_UPGRADE; o.new_phase = mglt_pkg::PH_ABORTED;
            return o;
         end
         hold_mode[i] = want;
         regroup(ent);
         o.group_mode = ent_grp[ent]; o.status = mglt_pkg::ST_GRANTED; return o;
      end
      if (ent >= 0) begin
         if (!fits_all(ent, -1, m)) begin
            o.status = mglt_pkg::ST_ABORT_CONFLICT; o.new_phase = mglt_pkg::PH_ABORTED;
            return o;
         end
         if (freeh < 0) begin
            o.status = mglt_pkg::ST_FULL; return o;
         end
         i = ent * HOLDERS_PER_ENTRY + freeh;
         hold_used[i] = 1'b1; hold_txn[i] = r.txn_id; hold_mode[i] = m;
         regroup(ent);
         o.group_mode = ent_grp[ent]; o.status = mglt_pkg::ST_GRANTED; return o;
      end
      for (int e = 0; e < LOCK_ENTRIES; e++)
         if (ent < 0 && !ent_used[e]) ent = e;
      if (ent < 0) begin
         o.status = mglt_pkg::ST_FULL; return o;
      end
      for (int h = 0; h < HOLDERS_PER_ENTRY; h++) hold_used[ent*HOLDERS_PER_ENTRY+h] = 1'b0;
      ent_used[ent] = 1'b1; ent_key[ent] = k;
      i = ent * HOLDERS_PER_ENTRY;
      hold_used[i] = 1'b1; hold_txn[i] = r.txn_id; hold_mode[i] = m;
      regroup(ent);
      o.group_mode = ent_grp[ent]; o.status = mglt_pkg::ST_GRANTED;
      return o;
   endfunction

   always @(posedge clock) begin
      mglt_pkg::rsp_type want;
      if (reset) begin
         fail_count <= 0;
         pending    <= 0;
         lock_results.delete();
         for (int e = 0; e < LOCK_ENTRIES; e++) begin
            ent_used[e] = 1'b0; ent_grp[e] = mglt_pkg::GRP_NONE;
         end
         for (int i = 0; i < NH; i++) hold_used[i] = 1'b0;
      end else begin
         // result side first so a same-edge request cannot be matched early
         if (rsp_valid && rsp_ready) begin
            if (lock_results.size() == 0) begin
               if (fail_count < 10) $display("unexpected result transfer %p", rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               want = lock_results.pop_front();
               if (rsp_data !== want) begin
                  if (fail_count < 10)
                     $display("mismatch: expected %p, actual %p", want, rsp_data);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_valid && req_ready) lock_results.push_back(lock_step(req_data));
         pending <= lock_results.size();
      end
   end

endmodule

FILE: dv/tb_multi_granularity_lock_table.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_multi_granularity_lock_table
// Drives directed and random lock/unlock traffic with bursty requests and a
// stalling receiver; the scoreboard predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_multi_granularity_lock_table;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   mglt_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_ready;
   mglt_pkg::rsp_type rsp_data;
   int                fail_count;
   int                pending;
   logic              hold_off;

   multi_granularity_lock_table u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   mglt_scoreboard u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .fail_count(fail_count), .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #40ms;
      $display("** multi_granularity_lock_table: FAILED **");
      $finish;
   end

   // receiver stall pattern, with one long hold-off while requests keep coming
   initial begin
      int mode_sel;
      logic held_done;
      rsp_ready = 1'b0;
      held_done = 1'b0;
      @(posedge clock);
      while (1) begin
         if (hold_off && !held_done) begin
            rsp_ready <= 1'b0;
            repeat (400) @(posedge clock);
            held_done = 1'b1;
         end
         mode_sel = $urandom_range(0, 3);
         repeat ($urandom_range(5, 40)) begin
            rsp_ready <= (mode_sel == 0) ? 1'b1 : ($urandom_range(0, mode_sel) == 0);
            @(posedge clock);
         end
      end
   end

   function automatic mglt_pkg::req_type make_req(input logic k, input logic [15:0] t,
                                                  input logic [1:0] ph,
                                                  input logic [2:0] m,
                                                  input logic [40:0] key);
      mglt_pkg::req_type r;
      r.kind = k; r.txn_present = 1'b1; r.txn_id = t; r.txn_phase = ph;
      r.access_mode = m;
      {r.target_is_record, r.table_id, r.page_number, r.slot_number} = key;
      return r;
   endfunction

   task automatic send(input mglt_pkg::req_type r);
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic gap();
      if ($urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 30)) @(posedge clock);
      end
   endtask

   logic [40:0] keys[8];

   initial begin
      mglt_pkg::req_type r;
      int n;
      logic [40:0] k;
      req_valid = 1'b0;
      req_data  = '0;
      hold_off  = 1'b0;
      reset     = 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      for (int i = 0; i < 8; i++) keys[i] = 41'({$urandom, $urandom});
      keys[0] = '0;
      keys[1] = '1;

      // directed: all modes but SIX, an undefined mode, upgrades, conflicts, phases, unlocks
      send(make_req(mglt_pkg::KIND_LOCK, 16'h0001, mglt_pkg::PH_DEFAULT,
                    mglt_pkg::MODE_S, keys[0]));
      send(make_req(mglt_pkg::KIND_LOCK, 16'h0001, mglt_pkg::PH_GROWING,
                    mglt_pkg::MODE_IX, keys[0]));
      send(make_req(mglt_pkg::KIND_LOCK, 16'h0002, mglt_pkg::PH_GROWING,
                    mglt_pkg::MODE_IS, keys[0]));
      send(make_req(mglt_pkg::KIND_LOCK, 16'h0002, mglt_pkg::PH_GROWING,
                    mglt_pkg::MODE_X, keys[0]));
      send(make_req(mglt_pkg::KIND_LOCK, 16'h0003, mglt_pkg::PH_DEFAULT,
                    mglt_pkg::MODE_IX, keys[0]));
      send(make_req(mglt_pkg::KIND_LOCK, 16'hFFFF, mglt_pkg::PH_ABORTED, 3'd7, keys[1]));
      send(make_req(mglt_pkg::KIND_LOCK, 16'h0004, mglt_pkg::PH_SHRINKING,
                    mglt_pkg::MODE_IS, keys[1]));
      send(make_req(mglt_pkg::KIND_LOCK, 16'h0004, mglt_pkg::PH_SHRINKING,
                    mglt_pkg::MODE_IS, keys[2]));
      send(make_req(mglt_pkg::KIND_UNLOCK, 16'h0005, mglt_pkg::PH_GROWING,
                    mglt_pkg::MODE_IS, keys[1]));
      send(make_req(mglt_pkg::KIND_UNLOCK, 16'h0005, mglt_pkg::PH_GROWING,
                    mglt_pkg::MODE_IS, keys[3]));
      send(make_req(mglt_pkg::KIND_UNLOCK, 16'hFFFF, mglt_pkg::PH_ABORTED,
                    mglt_pkg::MODE_IS, keys[1]));
      send(make_req(mglt_pkg::KIND_UNLOCK, 16'h0001, mglt_pkg::PH_GROWING,
                    mglt_pkg::MODE_IS, keys[0]));
      send(make_req(mglt_pkg::KIND_UNLOCK, 16'h0002, mglt_pkg::PH_DEFAULT,
                    mglt_pkg::MODE_IS, keys[0]));
      r = make_req(mglt_pkg::KIND_LOCK, 16'h0006, mglt_pkg::PH_GROWING,
                   mglt_pkg::MODE_X, keys[2]);
      r.txn_present = 1'b0;
      send(r);
      // holder list full on one key
      for (int t = 0; t < 9; t++)
         send(make_req(mglt_pkg::KIND_LOCK, 16'(32'h0100 + t), mglt_pkg::PH_GROWING,
                       mglt_pkg::MODE_IS, keys[4]));
      // fill the entry table
      for (int e = 0; e < 66; e++) begin
         k = {1'b1, 8'hA5, 20'(e), 12'h000};
         send(make_req(mglt_pkg::KIND_LOCK, 16'h0200, mglt_pkg::PH_GROWING, e[2:0], k));
      end
      // long receiver hold-off while requests keep coming
      hold_off = 1'b1;
      for (int e = 0; e < 66; e++) begin
         k = {1'b1, 8'hA5, 20'(e), 12'h000};
         send(make_req(mglt_pkg::KIND_UNLOCK, 16'h0200, mglt_pkg::PH_ABORTED,
                       mglt_pkg::MODE_IS, k));
      end

      // random: mostly traffic on a small key/txn pool, some full-range noise
      n = 0;
      while (n < 545) begin
         if ($urandom_range(0, 9) == 0) begin
            r = mglt_pkg::req_type'({$urandom, $urandom});
         end else begin
            r = make_req($urandom_range(0, 2) == 0, 16'($urandom_range(0, 5)),
                         2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
                         keys[$urandom_range(0, 7)]);
            if ($urandom_range(0, 3) != 0 && r.txn_phase == mglt_pkg::PH_SHRINKING)
               r.txn_phase = mglt_pkg::PH_GROWING;
            if ($urandom_range(0, 30) == 0) r.txn_present = 1'b0;
         end
         send(r);
         n++;
         gap();
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (fail_count == 0)
         $display("** multi_granularity_lock_table: PASSED **");
      else
         $display("** multi_granularity_lock_table: FAILED **");
      $finish;
   end

endmodule
